// File: design/autorange_frequency_counter_top_assert.svh
// assertion macros for the autorange frequency counter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef AUTORANGE_FREQUENCY_COUNTER_TOP_ASSERT_SVH
`define AUTORANGE_FREQUENCY_COUNTER_TOP_ASSERT_SVH

// property checked outside reset
`define AFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("afc: property failed");

// property that also looks at reset itself
`define AFC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("afc: reset property failed");

`endif

// File: design/afc_pkg.sv
// shared types, constants and helpers for the autorange frequency counter
// no dependencies
package afc_pkg;

  localparam int CNT_W_DEF   = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int N_CMD       = 3;
  localparam int DATA_MAX    = 6;

  localparam logic [15:0] GATE_RESET = 16'd100;

  localparam logic [7:0] LCD_CLEAR   = 8'h01;
  localparam logic [7:0] LCD_LINE1   = 8'h82;
  localparam logic [7:0] LCD_LINE2   = 8'hC4;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_M     = 8'h4D;
  localparam logic [7:0] ASCII_K     = 8'h4B;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef struct packed {
    logic tick;
    logic edge_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_command;
    logic       last;
  } out_item_t;

  // status of the gate queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = LCD_CLEAR;
      2'd1:    b = LCD_LINE1;
      default: b = LCD_LINE2;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] dig_char(input logic [3:0] d);
    return ASCII_ZERO + {4'd0, d};
  endfunction

endpackage

// File: design/afc_front.sv
// front end: accepts items, counts edges and ticks, closes the gate
// depends on afc_pkg; feeds latched counts to afc_fifo
module afc_front #(
  parameter int COUNT_WIDTH = afc_pkg::CNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  afc_pkg::in_item_t      in_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data,
  input  afc_pkg::q_stat_t       q_stat,
  output logic                   q_push,
  output logic [COUNT_WIDTH-1:0] q_data
);
  import afc_pkg::*;

  logic [15:0]            gate_r, gate_nxt;
  logic [15:0]            tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] pc_r, pc_nxt;
  logic [15:0]            tc_inc;
  logic [COUNT_WIDTH-1:0] pc_inc;
  logic                   accept;
  logic                   close;

  assign accept    = in_push && !q_stat.full;
  assign in_full   = q_stat.full;
  assign cfg_ready = 1'b1;

  assign tc_inc = tick_r + 16'd1;
  // saturating edge count, this item's edge belongs to the closing gate
  assign pc_inc = (in_item.edge_req && (pc_r != '1)) ? pc_r + COUNT_WIDTH'(1) : pc_r;
  assign close  = in_item.tick && (tc_inc >= gate_r);

  assign q_push = accept && close;
  assign q_data = pc_inc;

  always_comb begin
    gate_nxt = cfg_valid ? cfg_data : gate_r;
    tick_nxt = tick_r;
    pc_nxt   = pc_r;
    if (accept) begin
      pc_nxt = pc_inc;
      if (in_item.tick) begin
        tick_nxt = close ? 16'd0 : tc_inc;
      end
      if (close) begin
        pc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r <= GATE_RESET;
      tick_r <= '0;
      pc_r   <= '0;
    end else begin
      gate_r <= gate_nxt;
      tick_r <= tick_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

// File: design/afc_fifo.sv
// short queue of latched gate counts between front and back
// depends on afc_pkg for the status struct
module afc_fifo #(
  parameter int WIDTH = afc_pkg::CNT_W_DEF,
  parameter int DEPTH = afc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output afc_pkg::q_stat_t stat
);
  import afc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: design/afc_back.sv
// back end: binary to bcd one bit a cycle, range choice, lcd byte emitter
// depends on afc_pkg; takes counts from afc_fifo, drives the result register
module afc_back #(
  parameter int COUNT_WIDTH = afc_pkg::CNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  afc_pkg::q_stat_t       q_stat,
  input  logic [COUNT_WIDTH-1:0] q_data,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output afc_pkg::out_item_t     out_item
);
  import afc_pkg::*;

  // enough decimal digits for the count, never fewer than ten
  localparam int NDIG_RAW = (COUNT_WIDTH * 30103) / 100000 + 1;
  localparam int NDIG     = (NDIG_RAW < 10) ? 10 : NDIG_RAW;
  localparam int BW       = 4 * NDIG;
  localparam int BITW     = $clog2(COUNT_WIDTH);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_BUILD, S_EMIT} state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] sh_r, sh_nxt;
  logic [BW-1:0]          bcd_r, bcd_nxt;
  logic [BITW-1:0]        bit_r, bit_nxt;
  logic [7:0]             dl_r [DATA_MAX];
  logic [7:0]             dl_nxt [DATA_MAX];
  logic [7:0]             dl_b [DATA_MAX];
  logic [2:0]             nd_r, nd_nxt, nd_b;
  logic [3:0]             idx_r, idx_nxt;
  logic                   ov_r, ov_nxt;
  out_item_t              oi_r, oi_nxt;
  out_item_t              emit_item;
  logic [BW-1:0]          adj;
  logic [3:0]             d [NDIG];
  logic [3:0]             di;
  logic                   hi_nz, sat;
  logic [3:0]             m3, m2, m1, m0;

  assign out_empty = !ov_r;
  assign out_item  = oi_r;

  // add-3 correction on every digit before the shift
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      d[i] = bcd_r[4*i +: 4];
    end
    hi_nz = 1'b0;
    for (int i = 6; i < NDIG; i++) begin
      hi_nz = hi_nz || (d[i] != 4'd0);
    end
    sat = 1'b0;
    for (int i = 10; i < NDIG; i++) begin
      sat = sat || (d[i] != 4'd0);
    end
  end

  // megahertz reading clamps at 9999
  assign m3 = sat ? 4'd9 : d[9];
  assign m2 = sat ? 4'd9 : d[8];
  assign m1 = sat ? 4'd9 : d[7];
  assign m0 = sat ? 4'd9 : d[6];

  // data characters of the reading
  always_comb begin
    for (int i = 0; i < DATA_MAX; i++) begin
      dl_b[i] = ASCII_SPACE;
    end
    if (hi_nz) begin
      dl_b[0] = dig_char(m3);
      dl_b[1] = dig_char(m2);
      dl_b[2] = dig_char(m1);
      dl_b[3] = dig_char(m0);
      dl_b[4] = ASCII_M;
      nd_b    = 3'd5;
    end else if (d[5] != 4'd0) begin
      dl_b[0] = dig_char(d[5]);
      dl_b[1] = dig_char(d[4]);
      dl_b[2] = dig_char(d[3]);
      dl_b[3] = ASCII_K;
      nd_b    = 3'd4;
    end else if (d[4] != 4'd0) begin
      dl_b[0] = dig_char(d[4]);
      dl_b[1] = dig_char(d[3]);
      dl_b[2] = ASCII_DOT;
      dl_b[3] = dig_char(d[2]);
      dl_b[4] = ASCII_K;
      nd_b    = 3'd5;
    end else if (d[3] != 4'd0) begin
      // tenths of kHz with the tens digit suppressed
      dl_b[0] = dig_char(d[3]);
      dl_b[1] = ASCII_DOT;
      dl_b[2] = dig_char(d[2]);
      dl_b[3] = ASCII_K;
      nd_b    = 3'd4;
    end else if (d[2] != 4'd0) begin
      dl_b[0] = dig_char(d[2]);
      dl_b[1] = dig_char(d[1]);
      dl_b[2] = dig_char(d[0]);
      nd_b    = 3'd6;
    end else if (d[1] != 4'd0) begin
      dl_b[0] = dig_char(d[1]);
      dl_b[1] = dig_char(d[0]);
      nd_b    = 3'd5;
    end else begin
      dl_b[0] = dig_char(d[0]);
      nd_b    = 3'd4;
    end
  end

  assign di = idx_r - 4'(N_CMD);

  always_comb begin
    if (idx_r < 4'(N_CMD)) begin
      emit_item.lcd_byte   = cmd_byte(idx_r[1:0]);
      emit_item.is_command = 1'b1;
    end else begin
      emit_item.lcd_byte   = dl_r[di[2:0]];
      emit_item.is_command = 1'b0;
    end
    emit_item.last = (idx_r == ({1'b0, nd_r} + 4'(N_CMD - 1)));
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    bit_nxt   = bit_r;
    dl_nxt    = dl_r;
    nd_nxt    = nd_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    oi_nxt    = oi_r;
    q_pop     = 1'b0;
    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          sh_nxt    = q_data;
          bcd_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {adj[BW-2:0], sh_r[COUNT_WIDTH-1]};
        sh_nxt  = {sh_r[COUNT_WIDTH-2:0], 1'b0};
        bit_nxt = bit_r + BITW'(1);
        if (bit_r == BITW'(COUNT_WIDTH - 1)) begin
          state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        dl_nxt    = dl_b;
        nd_nxt    = nd_b;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_pop) begin
          ov_nxt  = 1'b1;
          oi_nxt  = emit_item;
          idx_nxt = idx_r + 4'd1;
          if (emit_item.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    bit_r <= bit_nxt;
    dl_r  <= dl_nxt;
    nd_r  <= nd_nxt;
    idx_r <= idx_nxt;
    oi_r  <= oi_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// File: design/autorange_frequency_counter_top.sv
// top level of the autorange frequency counter
// depends on afc_pkg, afc_front, afc_fifo and afc_back
//
//   channel  ports                          handshake
//   input    in_push in_full in_item        push && !full
//   result   out_empty out_pop out_item     pop && !empty
//   config   cfg_valid cfg_ready cfg_data   valid && ready
//
// one input item per clock while in_full is low; in_full rises only while two closed gates wait
// a closed gate goes through bcd conversion and range choice in the back end,
// then 7 to 9 result bytes at one per clock while each byte is popped as it shows
// result register lets the back end run on while a byte waits to be popped
// synchronous reset: counters clear, gate_r returns to 100
module autorange_frequency_counter_top #(
  parameter int COUNT_WIDTH = afc_pkg::CNT_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  afc_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output afc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import afc_pkg::*;

  q_stat_t                q_stat;
  logic                   q_push, q_pop;
  logic [COUNT_WIDTH-1:0] q_wdata, q_rdata;

  afc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  afc_fifo #(.WIDTH(COUNT_WIDTH), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  afc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: design/afc_chk.sv
// port-level checker for the autorange frequency counter, bound to the top
// depends on afc_pkg and autorange_frequency_counter_top_assert.svh
`include "autorange_frequency_counter_top_assert.svh"

module afc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input afc_pkg::out_item_t out_item
);
  import afc_pkg::*;

  logic take, shown, take_clear, take_line2, next_line1, hold;

  assign take       = out_pop && !out_empty;
  assign shown      = !out_empty;
  assign take_clear = take && out_item.is_command && (out_item.lcd_byte == LCD_CLEAR);
  assign take_line2 = take && out_item.is_command && (out_item.lcd_byte == LCD_LINE2);
  assign next_line1 = shown && out_item.is_command && (out_item.lcd_byte == LCD_LINE1);
  assign hold       = shown && !out_pop;

  // nothing waits on either side straight after reset
  `AFC_ASSERT_RST(a_reset_idle, !rst_n |=> out_empty && !in_full)
  // a popped clear or line2 command is followed at once by the next byte
  `AFC_ASSERT(a_clear_then_line1, take_clear |=> next_line1)
  `AFC_ASSERT(a_line2_then_data, take_line2 |=> shown && !out_item.is_command)
  // a waiting byte holds until it is popped
  `AFC_ASSERT(a_hold_result, hold |=> shown && $stable(out_item))

endmodule

bind autorange_frequency_counter_top afc_chk u_chk (.*);
